/* hdl/trapezoid_profile_planner_core_assert.svh */
// Assertion macros for the trapezoid profile planner checker.
// Each macro expects clk and rst_n in scope.
`ifndef TRAPEZOID_PROFILE_PLANNER_CORE_ASSERT_SVH
`define TRAPEZOID_PROFILE_PLANNER_CORE_ASSERT_SVH

// same-cycle implication
`define TPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpp check failed");

// next-cycle implication
`define TPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpp check failed");

`endif

/* hdl/tpp_pkg.sv */
// Shared types, constants and helpers for the trapezoid profile planner.
// No dependencies.
`timescale 1ns / 1ps
package tpp_pkg;
  localparam int MAG_W = 39;
  localparam int OP_W  = MAG_W + 1;
  localparam int QV_W  = 44;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 1;
  localparam int EPS_SCALE = 1000000;

  typedef logic signed [QV_W-1:0] qv_t;
  typedef logic signed [OP_W-1:0] opnd_t;

  localparam logic [MAG_W-1:0] Q_SAT_MAG = {1'b0, {(MAG_W-1){1'b1}}};
  localparam qv_t Q_SAT  = qv_t'(Q_SAT_MAG);
  localparam qv_t VP_MAX = (qv_t'(1) <<< 31) - qv_t'(1);
  localparam qv_t VP_MIN = -(qv_t'(1) <<< 31);

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VLIM  = 1'b1;
  localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    opnd_t      x;
    opnd_t      y;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    opnd_t res;
  } unit_rsp_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] peak;
    logic [30:0]        ptime;
    logic               last;
  } plan_rsp_t;

  function automatic qv_t sat_q(qv_t x);
    if (x > Q_SAT) return Q_SAT;
    if (x < -Q_SAT) return -Q_SAT;
    return x;
  endfunction

  function automatic qv_t abs_q(qv_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic opnd_t to_opnd(qv_t x);
    return x[OP_W-1:0];
  endfunction

  function automatic qv_t from_opnd(opnd_t x);
    return qv_t'(x);
  endfunction
endpackage

/* hdl/tpp_in_if.sv */
// Input channel of the trapezoid profile planner: one axis request per beat.
// No dependencies.
`timescale 1ns / 1ps
interface tpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_position;
  logic signed [31:0] start_velocity;
  logic signed [31:0] target_position;
  logic [30:0]        min_time;
  logic               last_axis;

  modport source(output valid, start_position, start_velocity, target_position,
                 min_time, last_axis, input ready);
  modport sink(input valid, start_position, start_velocity, target_position,
               min_time, last_axis, output ready);
endinterface

/* hdl/tpp_out_if.sv */
// Result channel of the trapezoid profile planner: one profile per beat.
// No dependencies.
`timescale 1ns / 1ps
interface tpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] peak_velocity;
  logic [30:0]        profile_time;
  logic [30:0]        longest_time;
  logic               last_flag;

  modport source(output valid, peak_velocity, profile_time, longest_time, last_flag,
                 input ready);
  modport sink(input valid, peak_velocity, profile_time, longest_time, last_flag,
               output ready);
endinterface

/* hdl/tpp_iter_unit.sv */
// Shared iterative unit: Q multiply (shift-add), Q divide (restoring),
// floor square root (two bits a step). Depends on tpp_pkg.
`timescale 1ns / 1ps
module tpp_iter_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpp_pkg::unit_req_t req,
  output tpp_pkg::unit_rsp_t rsp
);
  import tpp_pkg::*;

  localparam int NW     = MAG_W + FRAC_BITS;
  localparam int SQ     = (NW + 1) / 2;
  localparam int SH_W   = 2 * SQ;
  localparam int PROD_W = 2 * MAG_W;
  localparam int CNT_W  = $clog2(SH_W + 1);

  logic              busy_r, busy_nxt;
  logic              fin_r, fin_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic              nz_r, nz_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [MAG_W-1:0]  b_r, b_nxt;
  logic [SH_W-1:0]   q_r, q_nxt;

  logic [MAG_W-1:0]  ma, mb;
  logic [PROD_W-1:0] mul_sum;
  logic [MAG_W:0]    div_t, div_d;
  logic              div_ge;
  logic [SQ+1:0]     sq_t, sq_trial, sq_d;
  logic              sq_ge;
  logic [PROD_W-1:0] prod_sh;
  logic [MAG_W-1:0]  mag_res;

  function automatic logic [MAG_W-1:0] mag_of(opnd_t v);
    opnd_t t;
    t = v[OP_W-1] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  assign ma = mag_of(req.x);
  assign mb = mag_of(req.y);

  assign mul_sum  = {acc_r[PROD_W-2:0], 1'b0} + (sh_r[SH_W-1] ? PROD_W'(b_r) : '0);
  assign div_t    = {acc_r[MAG_W-1:0], sh_r[SH_W-1]};
  assign div_ge   = div_t >= {1'b0, b_r};
  assign div_d    = div_t - {1'b0, b_r};
  assign sq_t     = {acc_r[SQ-1:0], sh_r[SH_W-1:SH_W-2]};
  assign sq_trial = {q_r[SQ-1:0], 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_d     = sq_t - sq_trial;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    nz_nxt   = nz_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    q_nxt    = q_r;
    if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          acc_nxt = mul_sum;
          sh_nxt  = sh_r << 1;
        end
        OP_DIV: begin
          acc_nxt = PROD_W'(div_ge ? div_d[MAG_W-1:0] : div_t[MAG_W-1:0]);
          q_nxt   = {q_r[SH_W-2:0], div_ge};
          sh_nxt  = sh_r << 1;
        end
        OP_SQRT: begin
          acc_nxt = PROD_W'(sq_ge ? sq_d : sq_t);
          q_nxt   = {q_r[SH_W-2:0], sq_ge};
          sh_nxt  = sh_r << 2;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      neg_nxt  = req.x[OP_W-1] ^ req.y[OP_W-1];
      nz_nxt   = ma != '0;
      b_nxt    = mb;
      acc_nxt  = '0;
      q_nxt    = '0;
      sh_nxt   = SH_W'(ma) << (SH_W - MAG_W);
      case (req.op)
        OP_MUL:  cnt_nxt = CNT_W'(MAG_W);
        OP_DIV:  cnt_nxt = CNT_W'(NW);
        OP_SQRT: begin
          cnt_nxt = CNT_W'(SQ);
          neg_nxt = 1'b0;
          sh_nxt  = (req.x > 0) ? (SH_W'(ma) << FRAC_BITS) : '0;
        end
        default: cnt_nxt = CNT_W'(MAG_W);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    nz_r  <= nz_nxt;
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
  end

  assign prod_sh = acc_r >> FRAC_BITS;

  always_comb begin
    case (op_r)
      OP_MUL:  mag_res = (prod_sh > PROD_W'(Q_SAT_MAG)) ? Q_SAT_MAG : prod_sh[MAG_W-1:0];
      OP_DIV: begin
        if (!nz_r) mag_res = '0;
        else mag_res = (q_r > SH_W'(Q_SAT_MAG)) ? Q_SAT_MAG : q_r[MAG_W-1:0];
      end
      OP_SQRT: mag_res = MAG_W'(q_r[SQ-1:0]);
      default: mag_res = '0;
    endcase
  end

  assign rsp.done = fin_r;
  assign rsp.res  = neg_r ? -opnd_t'(mag_res) : opnd_t'(mag_res);
endmodule

/* hdl/tpp_seq.sv */
// Sequencer and working registers of the planner: steps the profile cases
// through the shared unit. Depends on tpp_pkg, tpp_in_if.
`timescale 1ns / 1ps
module tpp_seq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tpp_in_if.sink                       in_ch,
  input  logic [tpp_pkg::CFG_W-1:0]    accel,
  input  logic [tpp_pkg::CFG_W-1:0]    vlim,
  output tpp_pkg::unit_req_t           req,
  input  tpp_pkg::unit_rsp_t           rsp,
  output tpp_pkg::plan_rsp_t           res,
  input  logic                         res_ready
);
  import tpp_pkg::*;

  localparam qv_t TINY_MAX = qv_t'(((2 ** FRAC_BITS) - 1) / EPS_SCALE);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_T0   = 5'd2;
  localparam logic [4:0] S_WAIT = 5'd3;
  localparam logic [4:0] S_D1   = 5'd4;
  localparam logic [4:0] S_D1R  = 5'd5;
  localparam logic [4:0] S_A_SQ = 5'd6;
  localparam logic [4:0] S_A_VP = 5'd7;
  localparam logic [4:0] S_A_T1 = 5'd8;
  localparam logic [4:0] S_A_T2 = 5'd9;
  localparam logic [4:0] S_B_W  = 5'd10;
  localparam logic [4:0] S_B_A  = 5'd11;
  localparam logic [4:0] S_B_AD = 5'd12;
  localparam logic [4:0] S_B_VP = 5'd13;
  localparam logic [4:0] S_B_TL = 5'd14;
  localparam logic [4:0] S_B_T1 = 5'd15;
  localparam logic [4:0] S_B_T2 = 5'd16;
  localparam logic [4:0] S_B_T3 = 5'd17;
  localparam logic [4:0] S_S_AT = 5'd18;
  localparam logic [4:0] S_S_1  = 5'd19;
  localparam logic [4:0] S_S_2  = 5'd20;
  localparam logic [4:0] S_S_3  = 5'd21;
  localparam logic [4:0] S_DP0  = 5'd22;
  localparam logic [4:0] S_DP1  = 5'd23;
  localparam logic [4:0] S_DP2  = 5'd24;
  localparam logic [4:0] S_DP3  = 5'd25;
  localparam logic [4:0] S_FIN  = 5'd26;

  logic [4:0] state_r, state_nxt, ret_r, ret_nxt;
  opnd_t res_r, res_nxt;
  qv_t   v0_r, v0_nxt, d_r, d_nxt, a_r, a_nxt, t0_r, t0_nxt, w_r, w_nxt;
  qv_t   ad_r, ad_nxt, vp_r, vp_nxt, ts_r, ts_nxt, tmp_r, tmp_nxt;
  qv_t   tl_r, tl_nxt, den_r, den_nxt, tm_r, tm_nxt;
  logic  neg_r, neg_nxt, last_r, last_nxt;
  qv_t   vm, rq, vps, pk, tc;

  function automatic logic tiny(qv_t x);
    return (x <= TINY_MAX) && (x >= -TINY_MAX);
  endfunction

  assign vm = qv_t'(vlim);
  assign rq = from_opnd(res_r);
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    qv_t d1, dn, vpn, tsn, s, h;
    d1 = rq >>> 1;
    vpn = (rq > vm) ? vm : rq;
    state_nxt = state_r;
    ret_nxt = ret_r;
    res_nxt = res_r;
    v0_nxt = v0_r;  d_nxt = d_r;   a_nxt = a_r;   t0_nxt = t0_r;  w_nxt = w_r;
    ad_nxt = ad_r;  vp_nxt = vp_r; ts_nxt = ts_r; tmp_nxt = tmp_r;
    tl_nxt = tl_r;  den_nxt = den_r; tm_nxt = tm_r;
    neg_nxt = neg_r; last_nxt = last_r;
    req.start = 1'b0;
    req.op = OP_MUL;
    req.x = '0;
    req.y = '0;
    dn = '0;
    tsn = '0;
    s = '0;
    h = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          v0_nxt = qv_t'(in_ch.start_velocity);
          d_nxt = qv_t'(in_ch.target_position) - qv_t'(in_ch.start_position);
          tm_nxt = qv_t'(in_ch.min_time);
          last_nxt = in_ch.last_axis;
          a_nxt = qv_t'(accel);
          neg_nxt = 1'b0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (tiny(d_r) && tiny(v0_r)) begin
          vp_nxt = '0;
          ts_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          if (d_r < 0) begin
            neg_nxt = 1'b1;
            d_nxt = -d_r;
            v0_nxt = -v0_r;
          end
          state_nxt = S_T0;
        end
      end
      S_T0: begin
        req = '{1'b1, OP_DIV, to_opnd(abs_q(v0_r)), to_opnd(a_r)};
        ret_nxt = S_D1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) begin
          res_nxt = rsp.res;
          state_nxt = ret_r;
        end
      end
      S_D1: begin
        t0_nxt = rq;
        req = '{1'b1, OP_MUL, res_r, to_opnd(abs_q(v0_r))};
        ret_nxt = S_D1R;
        state_nxt = S_WAIT;
      end
      S_D1R: begin
        if (v0_r < 0) begin
          dn = sat_q(d_r + d1);
          d_nxt = dn;
          req = '{1'b1, OP_MUL, to_opnd(a_r), to_opnd(dn)};
          ret_nxt = S_A_SQ;
        end else begin
          tmp_nxt = d1;
          req = '{1'b1, OP_MUL, to_opnd(v0_r), to_opnd(v0_r)};
          ret_nxt = S_B_W;
        end
        state_nxt = S_WAIT;
      end
      S_A_SQ: begin
        req = '{1'b1, OP_SQRT, res_r, '0};
        ret_nxt = S_A_VP;
        state_nxt = S_WAIT;
      end
      S_A_VP: begin
        vp_nxt = vpn;
        req = '{1'b1, OP_DIV, to_opnd(d_r), to_opnd(vpn)};
        ret_nxt = S_A_T1;
        state_nxt = S_WAIT;
      end
      S_A_T1: begin
        tmp_nxt = rq;
        req = '{1'b1, OP_DIV, to_opnd(vp_r), to_opnd(a_r)};
        ret_nxt = S_A_T2;
        state_nxt = S_WAIT;
      end
      S_A_T2: begin
        ts_nxt = sat_q(tmp_r + rq + t0_r);
        state_nxt = S_FIN;
      end
      S_B_W: begin
        w_nxt = rq;
        if (d_r < tmp_r) begin
          req = '{1'b1, OP_DIV, res_r, to_opnd(sat_q(d_r + d_r))};
          ret_nxt = S_B_A;
        end else begin
          req = '{1'b1, OP_MUL, to_opnd(a_r), to_opnd(d_r)};
          ret_nxt = S_B_AD;
        end
        state_nxt = S_WAIT;
      end
      S_B_A: begin
        a_nxt = rq;
        req = '{1'b1, OP_MUL, res_r, to_opnd(d_r)};
        ret_nxt = S_B_AD;
        state_nxt = S_WAIT;
      end
      S_B_AD: begin
        ad_nxt = rq;
        req = '{1'b1, OP_SQRT, to_opnd(sat_q(rq + (w_r >>> 1))), '0};
        ret_nxt = S_B_VP;
        state_nxt = S_WAIT;
      end
      S_B_VP: begin
        vp_nxt = vpn;
        req = '{1'b1, OP_MUL, to_opnd(sat_q(a_r + a_r)), to_opnd(vpn)};
        ret_nxt = S_B_TL;
        state_nxt = S_WAIT;
      end
      S_B_TL: begin
        req = '{1'b1, OP_DIV, to_opnd(w_r), res_r};
        ret_nxt = S_B_T1;
        state_nxt = S_WAIT;
      end
      S_B_T1: begin
        tl_nxt = rq;
        req = '{1'b1, OP_DIV, to_opnd(d_r), to_opnd(vp_r)};
        ret_nxt = S_B_T2;
        state_nxt = S_WAIT;
      end
      S_B_T2: begin
        tmp_nxt = rq;
        if (v0_r <= vp_r) begin
          req = '{1'b1, OP_DIV, to_opnd(vp_r - v0_r), to_opnd(a_r)};
        end else begin
          req = '{1'b1, OP_DIV, to_opnd(v0_r), to_opnd(a_r)};
        end
        ret_nxt = S_B_T3;
        state_nxt = S_WAIT;
      end
      S_B_T3: begin
        if (v0_r <= vp_r) tsn = sat_q(tmp_r + rq + tl_r);
        else tsn = sat_q(tmp_r - tl_r + rq);
        ts_nxt = tsn;
        if (tsn < tm_r) begin
          ts_nxt = tm_r;
          if (v0_r <= vp_r) begin
            req = '{1'b1, OP_MUL, to_opnd(a_r), to_opnd(tm_r)};
            ret_nxt = S_S_AT;
            state_nxt = S_WAIT;
          end else begin
            state_nxt = S_DP0;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_S_AT: begin
        t0_nxt = rq;
        tmp_nxt = -(ad_r <<< 2) - w_r;
        req = '{1'b1, OP_MUL, res_r, to_opnd(v0_r)};
        ret_nxt = S_S_1;
        state_nxt = S_WAIT;
      end
      S_S_1: begin
        tmp_nxt = tmp_r + rq + rq;
        req = '{1'b1, OP_MUL, to_opnd(t0_r), to_opnd(t0_r)};
        ret_nxt = S_S_2;
        state_nxt = S_WAIT;
      end
      S_S_2: begin
        req = '{1'b1, OP_SQRT, to_opnd(sat_q(tmp_r + rq)), '0};
        ret_nxt = S_S_3;
        state_nxt = S_WAIT;
      end
      S_S_3: begin
        s = sat_q(v0_r + t0_r - rq);
        h = (s < 0) ? -((-s) >>> 1) : (s >>> 1);
        if (h < v0_r) begin
          state_nxt = S_DP0;
        end else begin
          vp_nxt = h;
          state_nxt = S_FIN;
        end
      end
      S_DP0: begin
        req = '{1'b1, OP_MUL, to_opnd(a_r), to_opnd(tm_r)};
        ret_nxt = S_DP1;
        state_nxt = S_WAIT;
      end
      S_DP1: begin
        dn = sat_q(v0_r - rq);
        den_nxt = dn;
        req = '{1'b1, OP_DIV, to_opnd(w_r), to_opnd(sat_q(dn + dn))};
        ret_nxt = S_DP2;
        state_nxt = S_WAIT;
      end
      S_DP2: begin
        tmp_nxt = rq;
        req = '{1'b1, OP_DIV, to_opnd(ad_r), to_opnd(den_r)};
        ret_nxt = S_DP3;
        state_nxt = S_WAIT;
      end
      S_DP3: begin
        vp_nxt = sat_q(tmp_r - rq);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
    res_r <= res_nxt;
    v0_r <= v0_nxt;  d_r <= d_nxt;   a_r <= a_nxt;   t0_r <= t0_nxt;  w_r <= w_nxt;
    ad_r <= ad_nxt;  vp_r <= vp_nxt; ts_r <= ts_nxt; tmp_r <= tmp_nxt;
    tl_r <= tl_nxt;  den_r <= den_nxt; tm_r <= tm_nxt;
    neg_r <= neg_nxt; last_r <= last_nxt;
  end

  assign vps = neg_r ? -vp_r : vp_r;
  assign pk  = (vps > VP_MAX) ? VP_MAX : ((vps < VP_MIN) ? VP_MIN : vps);
  assign tc  = (ts_r < 0) ? '0 : ((ts_r > VP_MAX) ? VP_MAX : ts_r);

  assign res.valid = (state_r == S_FIN);
  assign res.peak  = pk[31:0];
  assign res.ptime = tc[30:0];
  assign res.last  = last_r;
endmodule

/* hdl/trapezoid_profile_planner_core.sv */
// Trapezoid profile planner: one axis per beat, one result per beat.
// A zero move skips the shared unit; other moves run their multiplies, divides and
// roots one at a time through the shared multiply/divide/root unit, and a new
// axis is taken only once the last result has left the sequencer.
// Reset (synchronous, rst_n low): idle, output empty, running max 0,
// acceleration and velocity limit 65536.
`timescale 1ns / 1ps
module trapezoid_profile_planner_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tpp_in_if.sink                        in_ch,
  tpp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpp_pkg::CFG_W-1:0]     cfg_wdata
);
  import tpp_pkg::*;

  logic [CFG_W-1:0] accel_r, vlim_r;
  logic [30:0]      rmax_r, longest;
  logic             out_valid_r;
  logic signed [31:0] peak_r;
  logic [30:0]      ptime_r, longest_r;
  logic             last_r;
  logic             plan_ready, load;
  unit_req_t        ureq;
  unit_rsp_t        ursp;
  plan_rsp_t        plan;

  tpp_iter_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk(clk), .rst_n(rst_n), .req(ureq), .rsp(ursp)
  );

  tpp_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .accel(accel_r), .vlim(vlim_r),
    .req(ureq), .rsp(ursp), .res(plan), .res_ready(plan_ready)
  );

  assign plan_ready = !out_valid_r || out_ch.ready;
  assign load = plan.valid && plan_ready;
  assign longest = (plan.ptime > rmax_r) ? plan.ptime : rmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r     <= CFG_RESET;
      vlim_r      <= CFG_RESET;
      rmax_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_ACCEL) accel_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_VLIM) vlim_r <= cfg_wdata;
      if (load) begin
        rmax_r      <= plan.last ? '0 : longest;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      peak_r    <= plan.peak;
      ptime_r   <= plan.ptime;
      longest_r <= longest;
      last_r    <= plan.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.peak_velocity = peak_r;
  assign out_ch.profile_time  = ptime_r;
  assign out_ch.longest_time  = longest_r;
  assign out_ch.last_flag     = last_r;
endmodule

/* hdl/tpp_checker.sv */
// Port-level checks for the trapezoid profile planner, bound to the top.
// Depends on tpp_in_if, tpp_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "trapezoid_profile_planner_core_assert.svh"
module tpp_checker (
  input logic       clk,
  input logic       rst_n,
  tpp_in_if.sink    in_ch,
  tpp_out_if.source out_ch
);
  `TPP_ASSERT_NEXT(a_busy_after_beat, in_ch.valid && in_ch.ready, !in_ch.ready)
  `TPP_ASSERT_NOW(a_longest_covers, out_ch.valid, out_ch.longest_time >= out_ch.profile_time)
  `TPP_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

bind trapezoid_profile_planner_core tpp_checker u_tpp_checker (
  .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
);
